### design/vwvs_pkg.sv
package vwvs_pkg;

  localparam int MAX_HALF_WINDOW = 15;
  localparam int NCELLS          = 2 * MAX_HALF_WINDOW + 1;
  localparam int CELL_AW         = $clog2(NCELLS);
  localparam int CNT_W           = $clog2(NCELLS + 1);
  localparam int HW_W            = 4;
  localparam int SCORE_W         = 16;
  localparam int INDEX_W         = 32;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 32;
  localparam int S_DATA_W        = 48;
  localparam int M_DATA_W        = 40;

  localparam logic [HW_W-1:0] HALF_WINDOW_RESET = HW_W'(5);

  localparam logic OP_FRAME = 1'b0;
  localparam logic OP_END   = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_HALF_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIL_THRESH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_FRAME = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

### design/vwvs_cell.sv
module vwvs_cell
  import vwvs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cell_ctrl_t         ctrl,
  input  logic               prev_flag,
  input  logic [INDEX_W-1:0] prev_index,
  output logic               flag,
  output logic [INDEX_W-1:0] index
);

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear) begin
      flag <= 1'b0;
    end else if (ctrl.shift) begin
      flag <= prev_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      index <= prev_index;
    end
  end

endmodule

### design/vad_window_vote_smoother_top.sv
// Voice activity smoother: majority vote over a sliding window of 2W+1 frames.
// Input stream s_*: one word per frame, tuser is the op (frame or end of stream).
// Output stream m_*: one word per decided frame, tlast marks the final word of a flush.
// Config cfg_*: index and data, always ready; written while idle by user rule, unchecked.
// A frame word's decision, for the frame W frames back,
// sits in the output register the next cycle once more than W frames are held.
// An end word starts a flush of W words, one per cycle while they are taken, then
// clears the window; with W or fewer frames held, or W = 0, it only clears it.
// Frames live in a shift chain of 31 cells, newest in cell 0; a running silent
// count avoids summing the cells. The output register is the only buffer: a
// stalled receiver holds s_tready low and pauses the flush until the word is taken.
// Reset (synchronous, active high) empties the window and the output register and
// restores W = 5, threshold 0, start frame 0. Writing half_window empties the window.
module vad_window_vote_smoother_top
  import vwvs_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [S_DATA_W-1:0]   s_tdata,   // score[15:0], frame_index[47:16]
  input  logic                  s_tuser,   // op
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [M_DATA_W-1:0]   m_tdata,   // out_frame_index[31:0], is_speech[32], zero pad
  output logic                  m_tlast,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  state_t state, state_next;

  logic [HW_W-1:0]           half_window;
  logic signed [SCORE_W-1:0] silence_threshold;
  logic [INDEX_W-1:0]        start_frame;

  logic [CNT_W-1:0] held, held_next;
  logic [CNT_W-1:0] sil_cnt, sil_cnt_next;
  logic [CNT_W-1:0] flush_cnt, flush_cnt_next;
  logic [HW_W-1:0]  step, step_next;

  logic [INDEX_W-1:0] out_index, out_index_next;
  logic               out_speech, out_speech_next;
  logic               out_last, out_last_next;
  logic               load_out;

  cell_ctrl_t         ctrl;
  logic               feed_flag;
  logic               flags [NCELLS];
  logic [INDEX_W-1:0] idxs [NCELLS];

  logic                      cfg_fire, win_clear;
  logic                      out_free, in_fire, is_end;
  logic signed [SCORE_W-1:0] score;
  logic [INDEX_W-1:0]        fidx;
  logic                      new_sil;
  logic [CNT_W-1:0]          w5, two_w, n_win, held_inc, sum_cnt, cur_cnt;
  logic [CELL_AW-1:0]        flag_addr, idx_addr;
  logic                      sel_flag, pop_flag;
  logic [INDEX_W-1:0]        dec_idx;
  logic                      idx_above, frame_emit, frame_full, frame_speech;
  logic                      flush_speech, flush_done, flush_go, start_flush;

  // config
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign win_clear = cfg_fire && (cfg_index == CFG_HALF_WINDOW);

  always_ff @(posedge clk) begin
    if (rst) begin
      half_window       <= HALF_WINDOW_RESET;
      silence_threshold <= '0;
      start_frame       <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        CFG_HALF_WINDOW: half_window       <= cfg_data[HW_W-1:0];
        CFG_SIL_THRESH:  silence_threshold <= cfg_data[SCORE_W-1:0];
        CFG_START_FRAME: start_frame       <= cfg_data[INDEX_W-1:0];
        default: ;
      endcase
    end
  end

  // datapath helpers
  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE) && out_free;
  assign in_fire  = s_tvalid && s_tready;
  assign is_end   = (s_tuser == OP_END);
  assign score    = s_tdata[SCORE_W-1:0];
  assign fidx     = s_tdata[SCORE_W+INDEX_W-1:SCORE_W];
  assign new_sil  = (score >= silence_threshold);

  assign w5       = {1'b0, half_window};
  assign two_w    = {half_window, 1'b0};
  assign n_win    = two_w + CNT_W'(1);
  assign held_inc = held + CNT_W'(1);
  assign sum_cnt  = sil_cnt + {{(CNT_W-1){1'b0}}, new_sil};

  assign flag_addr = (state == ST_FLUSH) ? two_w : two_w - CNT_W'(1);
  assign idx_addr  = w5 - CNT_W'(1);
  assign sel_flag  = flags[flag_addr];
  assign pop_flag  = (half_window == '0) ? new_sil : sel_flag;
  assign dec_idx   = (half_window == '0 && state == ST_IDLE) ? fidx : idxs[idx_addr];
  assign idx_above = dec_idx > start_frame;

  assign frame_emit   = held_inc > w5;
  assign frame_full   = held_inc == n_win;
  assign frame_speech = ({sum_cnt, 1'b0} <= {1'b0, n_win}) && idx_above;

  assign cur_cnt      = (step == '0) ? flush_cnt
                                     : flush_cnt - {{(CNT_W-1){1'b0}}, sel_flag};
  assign flush_speech = ({cur_cnt, 1'b0} <= {1'b0, n_win}) && idx_above;
  assign flush_done   = step == half_window - HW_W'(1);
  assign flush_go     = (state == ST_FLUSH) && out_free;
  assign start_flush  = in_fire && is_end && (held > w5) && (half_window != '0);

  // cell chain
  assign feed_flag = (state == ST_FLUSH) ? 1'b0 : new_sil;

  for (genvar k = 0; k < NCELLS; k++) begin : g_cell
    if (k == 0) begin : g_head
      vwvs_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .prev_flag  (feed_flag),
        .prev_index (fidx),
        .flag       (flags[k]),
        .index      (idxs[k])
      );
    end else begin : g_body
      vwvs_cell u_cell (
        .clk        (clk),
        .rst        (rst),
        .ctrl       (ctrl),
        .prev_flag  (flags[k-1]),
        .prev_index (idxs[k-1]),
        .flag       (flags[k]),
        .index      (idxs[k])
      );
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (start_flush) state_next = ST_FLUSH;
      ST_FLUSH: if (flush_go && flush_done) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // control and outputs
  always_comb begin
    ctrl            = '0;
    held_next       = held;
    sil_cnt_next    = sil_cnt;
    flush_cnt_next  = flush_cnt;
    step_next       = step;
    load_out        = 1'b0;
    out_index_next  = dec_idx;
    out_speech_next = frame_speech;
    out_last_next   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (in_fire && !is_end) begin
          ctrl.shift = 1'b1;
          load_out   = frame_emit;
          if (frame_full) begin
            held_next    = two_w;
            sil_cnt_next = sum_cnt - {{(CNT_W-1){1'b0}}, pop_flag};
          end else begin
            held_next    = held_inc;
            sil_cnt_next = sum_cnt;
          end
        end else if (start_flush) begin
          flush_cnt_next = sil_cnt;
          step_next      = '0;
        end else if (in_fire) begin
          ctrl.clear   = 1'b1;
          held_next    = '0;
          sil_cnt_next = '0;
        end
      end
      ST_FLUSH: begin
        if (flush_go) begin
          load_out        = 1'b1;
          out_speech_next = flush_speech;
          out_last_next   = flush_done;
          flush_cnt_next  = cur_cnt;
          ctrl.shift      = 1'b1;
          step_next       = step + HW_W'(1);
          if (flush_done) begin
            ctrl.clear   = 1'b1;
            held_next    = '0;
            sil_cnt_next = '0;
            step_next    = '0;
          end
        end
      end
      default: ;
    endcase
    if (win_clear) begin
      ctrl.clear   = 1'b1;
      held_next    = '0;
      sil_cnt_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      held      <= '0;
      sil_cnt   <= '0;
      flush_cnt <= '0;
      step      <= '0;
    end else begin
      state     <= state_next;
      held      <= held_next;
      sil_cnt   <= sil_cnt_next;
      flush_cnt <= flush_cnt_next;
      step      <= step_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_index  <= out_index_next;
      out_speech <= out_speech_next;
      out_last   <= out_last_next;
    end
  end

  assign m_tdata = {{(M_DATA_W-INDEX_W-1){1'b0}}, out_speech, out_index};
  assign m_tlast = out_last;

endmodule
